// ===== hdl/sfla_pkg.sv =====
package sfla_pkg;

    localparam int TABLE_SIZE = 26;
    localparam int OVERLAP    = 20;
    localparam int PCT_SCALE  = 100;

    localparam logic [8:0] LINK_NONE = 9'd256;
    localparam logic [6:0] PCT_FULL  = 7'd100;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

    typedef logic [2:0] bucket_tab_t [TABLE_SIZE];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PREP,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/slot_free_list_allocator_unit.sv =====
// channel   ports                                        direction
// request   s_valid s_ready s_kind s_slot                in
// result    m_valid m_ready m_granted_slot m_status      out
//           m_free_slots m_occupancy_percent m_bucket
//           m_pool_full m_pool_empty
// config    cfg_we cfg_wdata                             in
//
// one request at a time; the link memory read issues at acceptance, then the lookup state
// does the update, the prep state forms the numerator, seven divide steps follow and the finish
// state loads the result register; no new request is taken until the unit is back in idle.
// a request is accepted while a result waits; it then stalls in the finish state until drained.
// reset (aresetn low, synchronous) gives slot count min(256,SLOTS) and an all-free pool;
// the link memory needs no clearing, the init horizon covers untouched slots.
module slot_free_list_allocator_unit
    import sfla_pkg::*;
#(
    parameter int SLOTS   = 256,
    parameter int BUCKETS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_slot,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_granted_slot,
    output logic [1:0] m_status,
    output logic [8:0] m_free_slots,
    output logic [6:0] m_occupancy_percent,
    output logic [2:0] m_bucket,
    output logic       m_pool_full,
    output logic       m_pool_empty
);

    localparam int MEM_DEPTH = (SLOTS < 256) ? SLOTS : 256;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [8:0] COUNT_TOP = 9'(MEM_DEPTH);
    localparam int DIV_D     = PCT_SCALE * BUCKETS;
    localparam int NUDGE     = (TABLE_SIZE * OVERLAP + 2 * DIV_D - 2) / DIV_D;
    localparam logic [2:0] BUCKET_TOP = 3'(BUCKETS - 1);

    function automatic bucket_tab_t build_table(input logic lower);
        bucket_tab_t tab;
        int c;
        int b;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (lower) begin
                c = (i > NUDGE) ? i - NUDGE : 0;
            end else begin
                c = (i + NUDGE < TABLE_SIZE - 1) ? i + NUDGE : TABLE_SIZE - 1;
            end
            b = c * BUCKETS / TABLE_SIZE;
            if (b > BUCKETS - 1) begin
                b = BUCKETS - 1;
            end
            tab[i] = 3'(b);
        end
        return tab;
    endfunction

    localparam bucket_tab_t LOWER_TAB = build_table(1'b1);
    localparam bucket_tab_t UPPER_TAB = build_table(1'b0);

    state_t state_reg, state_next;

    logic [8:0] slot_count_reg, slot_count_next;
    logic [7:0] head_slot_reg, head_slot_next;
    logic       head_valid_reg, head_valid_next;
    logic [8:0] horizon_reg, horizon_next;
    logic [8:0] free_total_reg, free_total_next;

    logic       kind_reg, kind_next;
    logic [7:0] slot_reg, slot_next;
    logic [7:0] granted_reg, granted_next;
    logic [1:0] status_reg, status_next;

    logic [14:0] rem_reg, rem_next;
    logic [6:0]  quo_reg, quo_next;
    logic [2:0]  step_reg, step_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_granted_reg, m_granted_next;
    logic [1:0] m_status_reg, m_status_next;
    logic [8:0] m_free_reg, m_free_next;
    logic [6:0] m_pct_reg, m_pct_next;
    logic [2:0] m_bucket_reg, m_bucket_next;
    logic       m_full_reg, m_full_next;
    logic       m_empty_reg, m_empty_next;

    // link memory, one read port and one write port
    logic [8:0]    link_mem [MEM_DEPTH];
    logic [8:0]    link_rd_reg;
    logic          mem_re;
    logic          mem_we;
    logic [AW-1:0] mem_rd_addr;
    logic [AW-1:0] mem_wr_addr;
    logic [8:0]    mem_wr_data;

    logic        s_accept;
    logic        out_open;
    logic        alloc_fail;
    logic        free_fail;
    logic [8:0]  horizon_inc;
    logic [8:0]  cfg_limited;
    logic [15:0] num_full;
    logic [15:0] div_shift;
    logic        div_ge;
    logic [6:0]  pct;
    logic [4:0]  pct_idx;
    logic [2:0]  bucket_sel;

    assign s_accept = s_valid && s_ready;
    assign out_open = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_re) begin
            link_rd_reg <= link_mem[mem_rd_addr];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_PREP;
            ST_PREP:   state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (step_reg == 3'd0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_open) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready     = 1'b0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_rd_addr = head_slot_reg[AW-1:0];
        mem_wr_addr = slot_reg[AW-1:0];
        mem_wr_data = head_valid_reg ? {1'b0, head_slot_reg} : LINK_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                mem_re  = s_valid;
            end
            ST_LOOKUP: begin
                mem_we = (kind_reg == KIND_FREE) && !free_fail;
            end
            ST_PREP, ST_DIVIDE, ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    assign alloc_fail  = (free_total_reg == 9'd0) || !head_valid_reg
                         || ({1'b0, head_slot_reg} >= slot_count_reg);
    assign free_fail   = ({1'b0, slot_reg} >= slot_count_reg)
                         || (free_total_reg >= slot_count_reg);
    assign horizon_inc = horizon_reg + 9'd1;

    always_comb begin
        priority if (cfg_wdata < 9'd2) begin
            cfg_limited = 9'd2;
        end else if (cfg_wdata > COUNT_TOP) begin
            cfg_limited = COUNT_TOP;
        end else begin
            cfg_limited = cfg_wdata;
        end
    end

    // ceil numerator: free * 100 + count - 1
    assign num_full  = 16'(free_total_reg) * 16'(PCT_SCALE) + 16'(slot_count_reg) - 16'd1;
    assign div_shift = 16'(slot_count_reg) << step_reg;
    assign div_ge    = {1'b0, rem_reg} >= div_shift;

    assign pct     = PCT_FULL - quo_reg;
    assign pct_idx = pct[6:2];

    always_comb begin
        if (32'(pct_idx) >= TABLE_SIZE) begin
            bucket_sel = BUCKET_TOP;
        end else if (kind_reg == KIND_FREE) begin
            bucket_sel = LOWER_TAB[pct_idx];
        end else begin
            bucket_sel = UPPER_TAB[pct_idx];
        end
    end

    // datapath
    always_comb begin
        slot_count_next = slot_count_reg;
        head_slot_next  = head_slot_reg;
        head_valid_next = head_valid_reg;
        horizon_next    = horizon_reg;
        free_total_next = free_total_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_granted_next  = m_granted_reg;
        m_status_next   = m_status_reg;
        m_free_next     = m_free_reg;
        m_pct_next      = m_pct_reg;
        m_bucket_next   = m_bucket_reg;
        m_full_next     = m_full_reg;
        m_empty_next    = m_empty_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    kind_next = s_kind;
                    slot_next = s_slot;
                end
            end
            ST_LOOKUP: begin
                granted_next = 8'd0;
                status_next  = STATUS_OK;
                if (kind_reg == KIND_ALLOC) begin
                    if (alloc_fail) begin
                        status_next = STATUS_FULL;
                    end else begin
                        granted_next = head_slot_reg;
                        if ({1'b0, head_slot_reg} == horizon_reg) begin
                            // untouched region, hand out in order
                            horizon_next = horizon_inc;
                            if (horizon_inc >= slot_count_reg) begin
                                head_valid_next = 1'b0;
                            end else begin
                                head_slot_next = horizon_inc[7:0];
                            end
                        end else if (link_rd_reg[8]) begin
                            head_valid_next = 1'b0;
                        end else begin
                            head_slot_next = link_rd_reg[7:0];
                        end
                        free_total_next = free_total_reg - 9'd1;
                    end
                end else begin
                    if (free_fail) begin
                        status_next = STATUS_BAD_FREE;
                    end else begin
                        head_slot_next  = slot_reg;
                        head_valid_next = 1'b1;
                        free_total_next = free_total_reg + 9'd1;
                    end
                end
            end
            ST_PREP: begin
                rem_next  = num_full[14:0];
                quo_next  = 7'd0;
                step_next = 3'd6;
            end
            ST_DIVIDE: begin
                if (div_ge) begin
                    rem_next = 15'({1'b0, rem_reg} - div_shift);
                end
                quo_next  = {quo_reg[5:0], div_ge};
                step_next = step_reg - 3'd1;
            end
            ST_FINISH: begin
                if (out_open) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = granted_reg;
                    m_status_next  = status_reg;
                    m_free_next    = free_total_reg;
                    m_pct_next     = pct;
                    m_bucket_next  = bucket_sel;
                    m_full_next    = (free_total_reg == 9'd0);
                    m_empty_next   = (free_total_reg == slot_count_reg);
                end
            end
            default: begin
            end
        endcase

        // writing the slot count re-initializes the pool
        if (cfg_we) begin
            slot_count_next = cfg_limited;
            head_slot_next  = 8'd0;
            head_valid_next = 1'b1;
            horizon_next    = 9'd0;
            free_total_next = cfg_limited;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= COUNT_TOP;
            head_slot_reg  <= 8'd0;
            head_valid_reg <= 1'b1;
            horizon_reg    <= 9'd0;
            free_total_reg <= COUNT_TOP;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            head_slot_reg  <= head_slot_next;
            head_valid_reg <= head_valid_next;
            horizon_reg    <= horizon_next;
            free_total_reg <= free_total_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        granted_reg   <= granted_next;
        status_reg    <= status_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        m_granted_reg <= m_granted_next;
        m_status_reg  <= m_status_next;
        m_free_reg    <= m_free_next;
        m_pct_reg     <= m_pct_next;
        m_bucket_reg  <= m_bucket_next;
        m_full_reg    <= m_full_next;
        m_empty_reg   <= m_empty_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_granted_slot      = m_granted_reg;
    assign m_status            = m_status_reg;
    assign m_free_slots        = m_free_reg;
    assign m_occupancy_percent = m_pct_reg;
    assign m_bucket            = m_bucket_reg;
    assign m_pool_full         = m_full_reg;
    assign m_pool_empty        = m_empty_reg;

endmodule

// ===== tb/slot_free_list_allocator_unit_tb.sv =====
`timescale 1ns / 100ps

module slot_free_list_allocator_unit_tb
    import sfla_pkg::*;
();

    localparam int BUCKETS        = 8;
    localparam int RESULT_LATENCY = 11;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic [7:0] granted;
        logic [1:0] status;
        logic [8:0] free_slots;
        logic [6:0] pct;
        logic [2:0] bucket;
        logic       full;
        logic       empty;
    } slot_reply_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [8:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic       s_kind;
    logic [7:0] s_slot;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_granted_slot;
    logic [1:0] m_status;
    logic [8:0] m_free_slots;
    logic [6:0] m_occupancy_percent;
    logic [2:0] m_bucket;
    logic       m_pool_full;
    logic       m_pool_empty;

    // shadow of the allocator
    int unsigned pool_size;
    int unsigned free_count;
    int unsigned fresh_mark;
    int unsigned top_slot;
    bit          top_valid;
    logic [8:0]  next_link [256];

    slot_reply_t replies_due [$];
    slot_reply_t got_reply;
    logic [7:0]  held_slots [$];
    bit          steady;
    bit          filling;
    int          errors;
    int          n_granted, n_freed, n_full_rejects, n_bad_frees, n_sizes;

    slot_free_list_allocator_unit dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_slot              (s_slot),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_granted_slot      (m_granted_slot),
        .m_status            (m_status),
        .m_free_slots        (m_free_slots),
        .m_occupancy_percent (m_occupancy_percent),
        .m_bucket            (m_bucket),
        .m_pool_full         (m_pool_full),
        .m_pool_empty        (m_pool_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timed out with %0d results outstanding", $time, replies_due.size());
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [2:0] bucket_of(int unsigned pct, bit lower);
        int unsigned idx, nudge, c, b;
        idx   = pct >> 2;
        nudge = (TABLE_SIZE * OVERLAP + 2 * (PCT_SCALE * BUCKETS) - 2) / (PCT_SCALE * BUCKETS);
        if (idx >= TABLE_SIZE)
            return 3'(BUCKETS - 1);
        if (lower)
            c = (idx > nudge) ? idx - nudge : 0;
        else
            c = (idx + nudge < TABLE_SIZE - 1) ? idx + nudge : TABLE_SIZE - 1;
        b = c * BUCKETS / TABLE_SIZE;
        return 3'((b < BUCKETS - 1) ? b : BUCKETS - 1);
    endfunction

    function automatic void reset_pool(int unsigned size);
        pool_size  = size;
        free_count = size;
        fresh_mark = 0;
        top_slot   = 0;
        top_valid  = 1'b1;
        held_slots.delete();
    endfunction

    // updates the shadow state for one accepted request and returns its reply
    function automatic slot_reply_t apply_request(logic kind, logic [7:0] slot);
        slot_reply_t r;
        int unsigned num;
        r = '0;
        r.status = STATUS_OK;
        if (kind == KIND_ALLOC) begin
            if (free_count == 0 || !top_valid || top_slot >= pool_size) begin
                r.status = STATUS_FULL;
            end else begin
                r.granted = top_slot[7:0];
                if (top_slot == fresh_mark) begin
                    // untouched region: hand out slots in order
                    fresh_mark++;
                    if (fresh_mark >= pool_size)
                        top_valid = 1'b0;
                    else
                        top_slot = fresh_mark;
                end else begin
                    if (next_link[top_slot[7:0]] >= LINK_NONE)
                        top_valid = 1'b0;
                    else
                        top_slot = 32'(next_link[top_slot[7:0]]);
                end
                free_count--;
            end
        end else begin
            if (slot >= pool_size || free_count >= pool_size) begin
                r.status = STATUS_BAD_FREE;
            end else begin
                next_link[slot] = top_valid ? 9'(top_slot) : LINK_NONE;
                top_slot  = slot;
                top_valid = 1'b1;
                free_count++;
            end
        end
        num          = free_count * PCT_SCALE;
        r.pct        = 7'(PCT_SCALE - (num + pool_size - 1) / pool_size);
        r.bucket     = bucket_of(r.pct, kind == KIND_FREE);
        r.free_slots = 9'(free_count);
        r.full       = (free_count == 0);
        r.empty      = (free_count == pool_size);
        return r;
    endfunction

    task automatic issue_request(input logic kind, input logic [7:0] slot);
        int unsigned gap;
        slot_reply_t r;
        gap = idle_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_slot  <= slot;
        do @(posedge aclk); while (!s_ready);
        r = apply_request(kind, slot);
        replies_due.push_back(r);
        if (r.status == STATUS_FULL)
            n_full_rejects++;
        else if (r.status == STATUS_BAD_FREE)
            n_bad_frees++;
        else if (kind == KIND_ALLOC) begin
            n_granted++;
            held_slots.push_back(r.granted);
        end else begin
            n_freed++;
            foreach (held_slots[i]) begin
                if (held_slots[i] == slot) begin
                    held_slots.delete(i);
                    break;
                end
            end
        end
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_slot_count(input logic [8:0] value);
        drain_results();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        reset_pool(value < 2 ? 2 : (value > 256 ? 256 : value));
        for (int i = 0; i < 256; i++) next_link[i] = next_link[i];
        n_sizes++;
    endtask

    task automatic check_field(input string field, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with no request outstanding, slot %0d status %0d",
                         $time, m_granted_slot, m_status);
                errors++;
            end else begin
                got_reply = replies_due.pop_front();
                check_field("granted_slot", got_reply.granted, m_granted_slot);
                check_field("status", got_reply.status, m_status);
                check_field("free_slots", got_reply.free_slots, m_free_slots);
                check_field("occupancy_percent", got_reply.pct, m_occupancy_percent);
                check_field("bucket", got_reply.bucket, m_bucket);
                check_field("pool_full", got_reply.full, m_pool_full);
                check_field("pool_empty", got_reply.empty, m_pool_empty);
            end
        end
    end

    // result side back-pressure
    initial begin
        int unsigned hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 30)
                    hold = idle_cycles();
            end
        end
    end

    task automatic test_default_pool();
        issue_request(KIND_ALLOC, 8'hff);
        issue_request(KIND_ALLOC, 8'h00);
        issue_request(KIND_FREE, 8'd255);   // never handed out, still accepted
        issue_request(KIND_ALLOC, 8'h5a);
        issue_request(KIND_FREE, 8'd1);
        issue_request(KIND_FREE, 8'd0);
        issue_request(KIND_ALLOC, 8'ha5);
        issue_request(KIND_FREE, 8'd0);
        issue_request(KIND_FREE, 8'd7);     // pool already all free
    endtask

    task automatic test_tiny_pool();
        write_slot_count(9'd0);             // saturates up to two slots
        issue_request(KIND_ALLOC, 8'h00);
        issue_request(KIND_ALLOC, 8'hff);
        issue_request(KIND_ALLOC, 8'h00);   // full
        issue_request(KIND_FREE, 8'd2);     // out of range
        issue_request(KIND_FREE, 8'd255);
        issue_request(KIND_FREE, 8'd1);
        issue_request(KIND_FREE, 8'd1);     // double free links the slot to itself
        issue_request(KIND_FREE, 8'd0);
        issue_request(KIND_ALLOC, 8'h00);
        issue_request(KIND_ALLOC, 8'h00);
        issue_request(KIND_ALLOC, 8'h00);
    endtask

    task automatic run_random_items(input int n);
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            steady = (i >= n / 4 && i < n / 4 + n / 8);
            if (n >= 100 && i == n / 2)
                drain_results();
            if (free_count == 0)
                filling = 1'b0;
            else if (free_count == pool_size)
                filling = 1'b1;
            else if ($urandom_range(0, 99) < 2)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                if ($urandom_range(0, 1))
                    issue_request(KIND_FREE, 8'($urandom_range(0, 255)));
                else
                    issue_request(KIND_ALLOC, 8'($urandom_range(0, 255)));
            end else if ((filling && r < 90) || (!filling && r >= 82) || held_slots.size() == 0) begin
                issue_request(KIND_ALLOC, 8'($urandom_range(0, 255)));
            end else begin
                issue_request(KIND_FREE, held_slots[$urandom_range(0, held_slots.size() - 1)]);
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [8:0] sizes [6];
        int         lens  [6];
        sizes = '{9'd1, 9'd3, 9'd17, 9'd100, 9'd511, 9'd256};
        lens  = '{50, 80, 120, 200, 440, 60};
        foreach (sizes[k]) begin
            write_slot_count(sizes[k]);
            run_random_items(lens[k]);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_kind    = KIND_ALLOC;
        s_slot    = '0;
        steady    = 1'b0;
        filling   = 1'b1;
        errors    = 0;
        reset_pool(256);
        for (int i = 0; i < 256; i++) next_link[i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_pool();
        test_tiny_pool();
        test_random_traffic();

        drain_results();
        repeat (4 * RESULT_LATENCY) @(posedge aclk);
        $display("covered %0d grants, %0d frees, %0d full rejects, %0d bad frees",
                 n_granted, n_freed, n_full_rejects, n_bad_frees);
        $display("across %0d pool size writes including saturated ones, %0d mismatches",
                 n_sizes, errors);
        if (errors == 0 && replies_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
